/* hw/rtl/rrts_pkg.sv */
// shared types, field widths and codes for the round-robin task scheduler
package rrts_pkg;

    // fixed field widths of the channels and the configuration port
    localparam int CMD_W  = 3;
    localparam int TASK_W = 4;
    localparam int BOX_W  = 2;
    localparam int MSG_W  = 16;
    localparam int CFG_W  = 5;

    // default sizes
    localparam int D_TASKS      = 16;
    localparam int D_MAILBOXES  = 4;
    localparam int D_FIFO_DEPTH = 8;
    localparam int D_MSG_WIDTH  = 16;

    // command codes
    localparam logic [CMD_W-1:0] CMD_START  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_TICK   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_FAULT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_EXIT   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SLEEP  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_WAKEUP = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SEND   = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RECV   = 3'd7;

    // task status codes
    localparam logic [1:0] ST_NONE   = 2'd0;
    localparam logic [1:0] ST_ACTIVE = 2'd1;
    localparam logic [1:0] ST_SLEEP  = 2'd2;
    localparam logic [1:0] ST_EXITED = 2'd3;

    // one result item
    typedef struct packed {
        logic [TASK_W-1:0] next_task;
        logic              all_idle;
        logic              ret_valid;
        logic [MSG_W-1:0]  ret_message;
        logic              wake_valid;
        logic [TASK_W-1:0] wake_task;
        logic [MSG_W-1:0]  wake_message;
        logic              dropped;
        logic              recv_refused;
    } t_res;

endpackage

/* hw/rtl/rrts_if.sv */
// valid/ready channel interfaces for command items and result items
interface rrts_cmd_if;
    import rrts_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [TASK_W-1:0] target_task;
    logic [BOX_W-1:0]  box;
    logic [MSG_W-1:0]  message;

    modport source (output valid, output cmd, output target_task, output box,
                    output message, input ready);
    modport sink   (input valid, input cmd, input target_task, input box,
                    input message, output ready);
endinterface

interface rrts_res_if;
    import rrts_pkg::*;

    logic              valid;
    logic              ready;
    logic [TASK_W-1:0] next_task;
    logic              all_idle;
    logic              ret_valid;
    logic [MSG_W-1:0]  ret_message;
    logic              wake_valid;
    logic [TASK_W-1:0] wake_task;
    logic [MSG_W-1:0]  wake_message;
    logic              dropped;
    logic              recv_refused;

    modport source (output valid, output next_task, output all_idle,
                    output ret_valid, output ret_message, output wake_valid,
                    output wake_task, output wake_message, output dropped,
                    output recv_refused, input ready);
    modport sink   (input valid, input next_task, input all_idle,
                    input ret_valid, input ret_message, input wake_valid,
                    input wake_task, input wake_message, input dropped,
                    input recv_refused, output ready);
endinterface

/* hw/rtl/rrts_ram.sv */
// generic simple dual-port ram with registered read
module rrts_ram #(
    parameter int W     = 16,
    parameter int DEPTH = 32
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [W-1:0]                            i_wdata,
    input  logic                                    i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [W-1:0]                            o_rdata
);
    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

/* hw/rtl/rrts_wrap_add.sv */
// shared add and wrap unit: sum, compare against a limit, wrapped sum
module rrts_wrap_add #(
    parameter int W = 8
) (
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    input  logic [W-1:0] i_lim,
    output logic [W-1:0] o_sum,
    output logic         o_ge,
    output logic [W-1:0] o_wrap
);
    logic [W-1:0] sum;

    assign sum    = i_a + i_b;
    assign o_sum  = sum;
    assign o_ge   = (sum >= i_lim);
    assign o_wrap = o_ge ? (sum - i_lim) : sum;
endmodule

/* hw/rtl/round_robin_task_scheduler.sv */
// top level: task status table, mailbox fifos and the command sequencer
//
// usage
//   commands arrive as items on i_cmd (valid/ready), one result item per
//   command leaves on o_res (valid/ready); the task count register is written
//   through i_cfg_we/i_cfg_data; the user must write it only while the block
//   is idle, which the block itself does not enforce
//   one command is worked on at a time; i_cmd.ready is high only while the
//   sequencer waits for a command
//   a command passes the exec step, the fifo read and pop steps when a message
//   is popped, k round-robin scan steps (k from 1 to task count) or, for start,
//   one sweep step per task, and then the output step
//   the scan visits one status entry per cycle through the shared add/wrap
//   unit, so the scan length sets the rate; the next command can be taken
//   once the result enters the output register
//   reset clears all task status to none, running task to 0, mailbox heads,
//   counts and waiters, and sets the task count to 1; fifo data is not reset
//   a result waits in the output register while o_res.ready is low; the next
//   command is still accepted and worked on, and holds in its final step
//   until the output register frees
module round_robin_task_scheduler #(
    parameter int TASKS      = rrts_pkg::D_TASKS,
    parameter int MAILBOXES  = rrts_pkg::D_MAILBOXES,
    parameter int FIFO_DEPTH = rrts_pkg::D_FIFO_DEPTH,
    parameter int MSG_WIDTH  = rrts_pkg::D_MSG_WIDTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [rrts_pkg::CFG_W-1:0] i_cfg_data,
    rrts_cmd_if.sink                   i_cmd,
    rrts_res_if.source                 o_res
);
    import rrts_pkg::*;

    localparam int TW  = $clog2(TASKS);
    localparam int CW  = $clog2(TASKS + 1);
    localparam int FW  = $clog2(FIFO_DEPTH);
    localparam int FCW = $clog2(FIFO_DEPTH + 1);
    localparam int BW  = (MAILBOXES > 1) ? $clog2(MAILBOXES) : 1;
    localparam int UW  = ((CW > FCW) ? CW : FCW) + 1;
    localparam int AW  = BW + FW;
    localparam int RDEPTH = 2 ** AW;
    localparam logic [FCW-1:0] FULL_CNT = FCW'(FIFO_DEPTH);

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_RD    = 3'd2;
    localparam logic [2:0] S_POP   = 3'd3;
    localparam logic [2:0] S_SWEEP = 3'd4;
    localparam logic [2:0] S_SCAN  = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0]       r_state, n_state;
    logic [CFG_W-1:0] r_cfg;

    // scheduler state
    logic [1:0]           r_status [TASKS];
    logic [TW-1:0]        r_cur;
    logic [FW-1:0]        r_head [MAILBOXES];
    logic [FCW-1:0]       r_cnt  [MAILBOXES];
    logic [MAILBOXES-1:0] r_wv;
    logic [TW-1:0]        r_wt   [MAILBOXES];

    // latched command item
    logic [CMD_W-1:0]     r_cmd;
    logic [TASK_W-1:0]    r_target;
    logic [BOX_W-1:0]     r_box;
    logic [MSG_WIDTH-1:0] r_msg;

    // scan / sweep position and step count
    logic [TW-1:0] r_pos;
    logic [CW-1:0] r_i;

    // result being built and the output register
    t_res r_res;
    t_res res_fin;
    t_res r_out;
    logic r_ovalid;

    logic           accept;
    logic           out_free;
    logic [CW-1:0]  n_eff;
    logic           box_ok;
    logic [BW-1:0]  bidx;
    logic [FW-1:0]  cur_head;
    logic [FCW-1:0] cur_cnt;
    logic           cur_wv;
    logic [TW-1:0]  cur_wt;

    // shared unit
    logic [UW-1:0] u_a, u_b, u_lim, u_sum, u_wrap;
    logic          u_ge;
    logic [TW-1:0] np;
    logic [1:0]    st_np;

    // message fifo memory
    logic                 ram_we, ram_re;
    logic [AW-1:0]        ram_waddr, ram_raddr;
    logic [MSG_WIDTH-1:0] ram_rdata;

    assign accept   = i_cmd.valid && i_cmd.ready;
    assign out_free = !r_ovalid || o_res.ready;

    // effective task count: zero acts as one, clipped at TASKS
    always_comb begin
        if (r_cfg == '0) begin
            n_eff = CW'(1);
        end else if (32'(r_cfg) > TASKS) begin
            n_eff = CW'(TASKS);
        end else begin
            n_eff = CW'(r_cfg);
        end
    end

    assign box_ok   = (32'(r_box) < MAILBOXES);
    assign bidx     = BW'(r_box);
    assign cur_head = r_head[bidx];
    assign cur_cnt  = r_cnt[bidx];
    assign cur_wv   = r_wv[bidx];
    assign cur_wt   = r_wt[bidx];

    // operand select for the shared add/wrap unit
    always_comb begin
        u_a   = '0;
        u_b   = '0;
        u_lim = UW'(FIFO_DEPTH);
        case (r_state)
            S_EXEC: begin
                // fifo tail = head + count, wrapped at depth
                u_a = UW'(cur_head);
                u_b = UW'(cur_cnt);
            end
            S_POP: begin
                u_a = UW'(cur_head);
                u_b = UW'(1);
            end
            S_SWEEP: begin
                u_a   = UW'(r_i);
                u_b   = UW'(1);
                u_lim = UW'(n_eff);
            end
            S_SCAN: begin
                u_a   = UW'(r_pos);
                u_b   = UW'(1);
                u_lim = UW'(n_eff);
            end
            default: begin
                u_a = '0;
            end
        endcase
    end

    rrts_wrap_add #(.W(UW)) u_wrap_add (
        .i_a    (u_a),
        .i_b    (u_b),
        .i_lim  (u_lim),
        .o_sum  (u_sum),
        .o_ge   (u_ge),
        .o_wrap (u_wrap)
    );

    // next scan position wraps to task 0, also when running task is past count
    assign np    = u_ge ? '0 : u_sum[TW-1:0];
    assign st_np = r_status[np];

    // finished result with the running task filled in
    always_comb begin
        res_fin           = r_res;
        res_fin.next_task = TASK_W'(r_cur);
    end

    // fifo write on a send with room, read of the head before a pop
    assign ram_we    = (r_state == S_EXEC) && (r_cmd == CMD_SEND) && box_ok &&
                       (cur_cnt < FULL_CNT);
    assign ram_waddr = {bidx, u_wrap[FW-1:0]};
    assign ram_re    = (r_state == S_RD);
    assign ram_raddr = {bidx, cur_head};

    rrts_ram #(.W(MSG_WIDTH), .DEPTH(RDEPTH)) u_fifo_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_msg),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_cmd.valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                case (r_cmd)
                    CMD_START: n_state = S_SWEEP;
                    CMD_SEND: begin
                        // a waiting receiver always finds a message after a send
                        n_state = (box_ok && cur_wv) ? S_RD : S_SCAN;
                    end
                    CMD_RECV: begin
                        n_state = (box_ok && !cur_wv && (cur_cnt != '0)) ? S_RD : S_SCAN;
                    end
                    default: n_state = S_SCAN;
                endcase
            end
            S_RD:  n_state = S_POP;
            S_POP: n_state = S_SCAN;
            S_SWEEP: begin
                if (u_ge) begin
                    n_state = S_OUT;
                end
            end
            S_SCAN: begin
                if ((st_np == ST_ACTIVE) || (r_i == n_eff - 1'b1)) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cfg    <= CFG_W'(1);
            r_cur    <= '0;
            r_wv     <= '0;
            r_ovalid <= 1'b0;
            for (int k = 0; k < TASKS; k++) begin
                r_status[k] <= ST_NONE;
            end
            for (int k = 0; k < MAILBOXES; k++) begin
                r_head[k] <= '0;
                r_cnt[k]  <= '0;
            end
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                r_cfg <= i_cfg_data;
            end

            // output register
            if ((r_state == S_OUT) && out_free) begin
                r_ovalid <= 1'b1;
            end else if (o_res.ready) begin
                r_ovalid <= 1'b0;
            end

            // scan starts just after the running task
            if ((n_state == S_SCAN) && (r_state != S_SCAN)) begin
                r_pos <= r_cur;
                r_i   <= '0;
            end

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_cmd    <= i_cmd.cmd;
                        r_target <= i_cmd.target_task;
                        r_box    <= i_cmd.box;
                        r_msg    <= MSG_WIDTH'(i_cmd.message);
                        r_res    <= '0;
                    end
                end
                S_EXEC: begin
                    case (r_cmd)
                        CMD_START: begin
                            r_i <= '0;
                        end
                        CMD_FAULT, CMD_SLEEP: begin
                            r_status[r_cur] <= ST_SLEEP;
                        end
                        CMD_EXIT: begin
                            r_status[r_cur] <= ST_EXITED;
                        end
                        CMD_WAKEUP: begin
                            if (32'(r_target) < TASKS) begin
                                r_status[TW'(r_target)] <= ST_ACTIVE;
                            end
                        end
                        CMD_SEND: begin
                            if (box_ok) begin
                                if (cur_cnt >= FULL_CNT) begin
                                    r_res.dropped <= 1'b1;
                                end else begin
                                    r_cnt[bidx] <= cur_cnt + 1'b1;
                                end
                            end
                        end
                        CMD_RECV: begin
                            if (box_ok) begin
                                if (cur_wv) begin
                                    r_res.recv_refused <= 1'b1;
                                end else if (cur_cnt == '0) begin
                                    // park the caller as the mailbox receiver
                                    r_wv[bidx]      <= 1'b1;
                                    r_wt[bidx]      <= r_cur;
                                    r_status[r_cur] <= ST_SLEEP;
                                end
                            end
                        end
                        default: begin
                            r_res.all_idle <= 1'b0;
                        end
                    endcase
                end
                S_POP: begin
                    r_head[bidx] <= u_wrap[FW-1:0];
                    r_cnt[bidx]  <= cur_cnt - 1'b1;
                    if (r_cmd == CMD_SEND) begin
                        // hand the head message to the waiting receiver
                        r_res.wake_valid   <= 1'b1;
                        r_res.wake_task    <= TASK_W'(cur_wt);
                        r_res.wake_message <= MSG_W'(ram_rdata);
                        r_status[cur_wt]   <= ST_ACTIVE;
                        r_wv[bidx]         <= 1'b0;
                    end else begin
                        r_res.ret_valid   <= 1'b1;
                        r_res.ret_message <= MSG_W'(ram_rdata);
                    end
                end
                S_SWEEP: begin
                    // start: activate one task per cycle, then run task 0
                    r_status[TW'(r_i)] <= ST_ACTIVE;
                    if (u_ge) begin
                        r_cur <= '0;
                    end else begin
                        r_i <= u_sum[CW-1:0];
                    end
                end
                S_SCAN: begin
                    if (st_np == ST_ACTIVE) begin
                        r_cur <= np;
                    end else begin
                        r_pos <= np;
                        r_i   <= r_i + 1'b1;
                        if (r_i == n_eff - 1'b1) begin
                            r_res.all_idle <= 1'b1;
                        end
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out <= res_fin;
                    end
                end
                default: begin
                    r_pos <= r_pos;
                end
            endcase
        end
    end

    assign i_cmd.ready = (r_state == S_IDLE);

    assign o_res.valid        = r_ovalid;
    assign o_res.next_task    = r_out.next_task;
    assign o_res.all_idle     = r_out.all_idle;
    assign o_res.ret_valid    = r_out.ret_valid;
    assign o_res.ret_message  = r_out.ret_message;
    assign o_res.wake_valid   = r_out.wake_valid;
    assign o_res.wake_task    = r_out.wake_task;
    assign o_res.wake_message = r_out.wake_message;
    assign o_res.dropped      = r_out.dropped;
    assign o_res.recv_refused = r_out.recv_refused;

endmodule

/* hw/rtl/rrts_check.sv */
// port-level assertions for the scheduler, bound to the top level
module rrts_check (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [rrts_pkg::TASK_W-1:0] i_next_task,
    input logic                        i_all_idle,
    input logic                        i_ret_valid,
    input logic [rrts_pkg::MSG_W-1:0]  i_ret_message,
    input logic                        i_wake_valid,
    input logic [rrts_pkg::TASK_W-1:0] i_wake_task,
    input logic [rrts_pkg::MSG_W-1:0]  i_wake_message,
    input logic                        i_dropped,
    input logic                        i_recv_refused
);
    import rrts_pkg::*;

    // one command at a time: busy right after an item is taken
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("command accepted while previous one still in work");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_next_task) &&
            $stable(i_all_idle) && $stable(i_ret_valid) && $stable(i_ret_message) &&
            $stable(i_wake_valid) && $stable(i_wake_task) && $stable(i_wake_message) &&
            $stable(i_dropped) && $stable(i_recv_refused)))
        else $error("result changed while stalled");

    // a recv return excludes every send outcome and a refusal
    a_ret_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_ret_valid) |-> (!i_wake_valid && !i_dropped && !i_recv_refused))
        else $error("recv return mixed with other outcomes");

    // unused message and task fields read as zero
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ((i_ret_valid || (i_ret_message == '0)) &&
            (i_wake_valid || ((i_wake_task == '0) && (i_wake_message == '0)))))
        else $error("payload field set without its valid bit");

endmodule

bind round_robin_task_scheduler rrts_check u_rrts_check (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_cmd.valid),
    .i_in_ready     (i_cmd.ready),
    .i_out_valid    (o_res.valid),
    .i_out_ready    (o_res.ready),
    .i_next_task    (o_res.next_task),
    .i_all_idle     (o_res.all_idle),
    .i_ret_valid    (o_res.ret_valid),
    .i_ret_message  (o_res.ret_message),
    .i_wake_valid   (o_res.wake_valid),
    .i_wake_task    (o_res.wake_task),
    .i_wake_message (o_res.wake_message),
    .i_dropped      (o_res.dropped),
    .i_recv_refused (o_res.recv_refused)
);

/* tb/tb.sv */
// self-checking testbench for the round-robin task scheduler with mailboxes
module tb;
    import rrts_pkg::*;

    localparam int TASKS      = D_TASKS;
    localparam int MAILBOXES  = D_MAILBOXES;
    localparam int FIFO_DEPTH = D_FIFO_DEPTH;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic [CMD_W-1:0]  cmd;
        logic [TASK_W-1:0] target_task;
        logic [BOX_W-1:0]  box;
        logic [MSG_W-1:0]  message;
    } t_sched_cmd;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CFG_W-1:0] i_cfg_data;

    rrts_cmd_if cmd_if();
    rrts_res_if res_if();

    round_robin_task_scheduler uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd_if),
        .o_res      (res_if)
    );

    always #5 i_clk = ~i_clk;

    // scheduler shadow state
    logic [CFG_W-1:0] task_count_reg;
    logic [1:0]       task_st [TASKS];
    int               cur_task;
    logic [MSG_W-1:0] box_mem [MAILBOXES][FIFO_DEPTH];
    int               box_head [MAILBOXES];
    int               box_cnt [MAILBOXES];
    bit               waiter_v [MAILBOXES];
    int               waiter_t [MAILBOXES];

    t_sched_cmd pending_cmds[$];
    t_res       expected_res[$];
    t_sched_cmd drv_item;
    int         cmd_gap;
    int         res_stall;
    int         fail_count = 0;
    int         cycle_count = 0;
    bit         calm = 1'b0;

    function automatic int live_count();
        if (task_count_reg == 0) return 1;
        if (task_count_reg > TASKS) return TASKS;
        return task_count_reg;
    endfunction

    function automatic logic [MSG_W-1:0] box_pop(int b);
        logic [MSG_W-1:0] m;
        m = box_mem[b][box_head[b]];
        box_head[b] = (box_head[b] + 1 >= FIFO_DEPTH) ? 0 : box_head[b] + 1;
        box_cnt[b]--;
        return m;
    endfunction

    // applies one command to the shadow state and returns its result item
    function automatic t_res sched_step(t_sched_cmd it);
        t_res r;
        int   n;
        int   b;
        int   w;
        int   tail;
        int   pos;
        bit   found;
        r = '0;
        n = live_count();
        b = it.box;
        case (it.cmd)
            CMD_START: begin
                for (int i = 0; i < n; i++) task_st[i] = ST_ACTIVE;
                cur_task = 0;
            end
            CMD_TICK: ;
            CMD_FAULT, CMD_SLEEP: task_st[cur_task] = ST_SLEEP;
            CMD_EXIT: task_st[cur_task] = ST_EXITED;
            CMD_WAKEUP: task_st[it.target_task] = ST_ACTIVE;
            CMD_SEND: begin
                if (b < MAILBOXES) begin
                    if (box_cnt[b] >= FIFO_DEPTH) begin
                        r.dropped = 1'b1;
                    end else begin
                        tail = box_head[b] + box_cnt[b];
                        if (tail >= FIFO_DEPTH) tail -= FIFO_DEPTH;
                        box_mem[b][tail] = it.message;
                        box_cnt[b]++;
                    end
                    // a waiting receiver takes the head at once
                    if (waiter_v[b] && box_cnt[b] > 0) begin
                        w = waiter_t[b];
                        r.wake_message = box_pop(b);
                        r.wake_valid   = 1'b1;
                        r.wake_task    = w[TASK_W-1:0];
                        task_st[w]     = ST_ACTIVE;
                        waiter_v[b]    = 1'b0;
                    end
                end
            end
            default: begin
                if (b < MAILBOXES) begin
                    if (waiter_v[b]) begin
                        r.recv_refused = 1'b1;
                    end else if (box_cnt[b] == 0) begin
                        waiter_v[b] = 1'b1;
                        waiter_t[b] = cur_task;
                        task_st[cur_task] = ST_SLEEP;
                    end else begin
                        r.ret_message = box_pop(b);
                        r.ret_valid   = 1'b1;
                    end
                end
            end
        endcase
        if (it.cmd != CMD_START) begin
            // round-robin pick, starting just after the running task
            pos = cur_task;
            found = 1'b0;
            for (int i = 0; i < n && !found; i++) begin
                pos = (pos + 1 >= n) ? 0 : pos + 1;
                if (task_st[pos] == ST_ACTIVE) begin
                    found = 1'b1;
                    cur_task = pos;
                end
            end
            r.all_idle = !found;
        end
        r.next_task = cur_task[TASK_W-1:0];
        return r;
    endfunction

    // mostly short pauses, a few long ones, none in calm phases
    function automatic int pick_pause();
        int r;
        r = $urandom_range(0, 99);
        if (calm) return 0;
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    // command driver
    always @(posedge i_clk) begin : driver
        t_res want;
        if (!i_rst_n) begin
            cmd_if.valid       <= 1'b0;
            cmd_if.cmd         <= CMD_TICK;
            cmd_if.target_task <= '0;
            cmd_if.box         <= '0;
            cmd_if.message     <= '0;
            cmd_gap = 0;
        end else begin
            if (cmd_if.valid && cmd_if.ready) begin
                want = sched_step(drv_item);
                expected_res.push_back(want);
            end
            if (!cmd_if.valid || cmd_if.ready) begin
                if (cmd_gap > 0) begin
                    cmd_gap--;
                    cmd_if.valid <= 1'b0;
                end else if (pending_cmds.size() > 0) begin
                    drv_item = pending_cmds.pop_front();
                    cmd_if.valid       <= 1'b1;
                    cmd_if.cmd         <= drv_item.cmd;
                    cmd_if.target_task <= drv_item.target_task;
                    cmd_if.box         <= drv_item.box;
                    cmd_if.message     <= drv_item.message;
                    cmd_gap = pick_pause();
                end else begin
                    cmd_if.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor with random back-pressure
    always @(posedge i_clk) begin : monitor
        t_res want;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            res_stall = 0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                if (expected_res.size() == 0) begin
                    $display("%0t: result item with none expected, actual next_task %0h",
                             $time, res_if.next_task);
                    fail_count++;
                end else begin
                    want = expected_res.pop_front();
                    check_field("next_task", want.next_task, res_if.next_task);
                    check_field("all_idle", want.all_idle, res_if.all_idle);
                    check_field("ret_valid", want.ret_valid, res_if.ret_valid);
                    check_field("ret_message", want.ret_message, res_if.ret_message);
                    check_field("wake_valid", want.wake_valid, res_if.wake_valid);
                    check_field("wake_task", want.wake_task, res_if.wake_task);
                    check_field("wake_message", want.wake_message, res_if.wake_message);
                    check_field("dropped", want.dropped, res_if.dropped);
                    check_field("recv_refused", want.recv_refused, res_if.recv_refused);
                end
            end
            if (res_stall > 0) begin
                res_stall--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
                res_stall = ($urandom_range(0, 3) == 0) ? pick_pause() : 0;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("round_robin_task_scheduler verification failed");
            $finish;
        end
    end

    task automatic queue_cmd(logic [CMD_W-1:0] c, int tgt, int b, int m);
        t_sched_cmd it;
        it.cmd = c;
        it.target_task = tgt[TASK_W-1:0];
        it.box = b[BOX_W-1:0];
        it.message = m[MSG_W-1:0];
        pending_cmds.push_back(it);
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_cmds.size() != 0 || cmd_if.valid || expected_res.size() != 0);
    endtask

    // register write, only once everything in flight has come back
    task automatic set_task_count(int v);
        wait_drained();
        repeat (4) @(negedge i_clk);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v[CFG_W-1:0];
        task_count_reg = v[CFG_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [CMD_W-1:0] pick_cmd();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4)  return CMD_START;
        if (r < 14) return CMD_TICK;
        if (r < 19) return CMD_FAULT;
        if (r < 24) return CMD_EXIT;
        if (r < 32) return CMD_SLEEP;
        if (r < 52) return CMD_WAKEUP;
        if (r < 76) return CMD_SEND;
        return CMD_RECV;
    endfunction

    // random commands, some in shapes that reach full fifos and woken receivers
    task automatic queue_random(int count);
        int done;
        int r;
        int b;
        int k;
        done = 0;
        queue_cmd(CMD_START, 0, 0, 0);
        done++;
        while (done < count) begin
            r = $urandom_range(0, 99);
            b = $urandom_range(0, 3);
            if (r < 8) begin
                // flood one mailbox, at times past its depth
                k = $urandom_range(6, 10);
                repeat (k) queue_cmd(CMD_SEND, $urandom_range(0, 15), b, $urandom);
                done += k;
            end else if (r < 18) begin
                // receiver parks, others run, then a sender wakes it
                queue_cmd(CMD_RECV, $urandom_range(0, 15), b, $urandom);
                k = $urandom_range(0, 2);
                repeat (k) queue_cmd(CMD_TICK, $urandom_range(0, 15), b, $urandom);
                queue_cmd(CMD_SEND, $urandom_range(0, 15), b, $urandom);
                done += k + 2;
            end else begin
                queue_cmd(pick_cmd(), $urandom_range(0, 15), b, $urandom);
                done++;
            end
        end
    endtask

    initial begin : stimulus
        int phase_counts [9];
        task_count_reg = 1;
        for (int i = 0; i < TASKS; i++) task_st[i] = ST_NONE;
        cur_task = 0;
        for (int b = 0; b < MAILBOXES; b++) begin
            box_head[b] = 0;
            box_cnt[b]  = 0;
            waiter_v[b] = 1'b0;
            waiter_t[b] = 0;
        end
        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_data <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed, task count still at its reset value
        queue_cmd(CMD_TICK, 0, 0, 0);          // nothing active yet
        queue_cmd(CMD_RECV, 0, 0, 0);          // empty box, caller parks
        queue_cmd(CMD_SEND, 0, 0, 16'hFFFF);   // hands over to the parked caller
        queue_cmd(CMD_WAKEUP, 15, 0, 0);       // beyond the count, not picked while the count stays at one
        queue_cmd(CMD_TICK, 0, 0, 0);

        set_task_count(4);
        queue_cmd(CMD_START, 0, 0, 0);
        queue_cmd(CMD_FAULT, 0, 0, 0);
        queue_cmd(CMD_EXIT, 0, 0, 0);
        queue_cmd(CMD_SLEEP, 0, 0, 0);
        queue_cmd(CMD_WAKEUP, 0, 0, 0);
        queue_cmd(CMD_WAKEUP, 3, 0, 0);
        queue_cmd(CMD_RECV, 0, 1, 0);
        queue_cmd(CMD_RECV, 0, 1, 0);          // second receiver refused
        queue_cmd(CMD_SEND, 0, 1, 16'h0000);
        for (int i = 0; i < FIFO_DEPTH + 1; i++) begin
            queue_cmd(CMD_SEND, 0, 2, 16'h1111 * (i + 1));   // last one dropped
        end
        queue_cmd(CMD_RECV, 0, 2, 0);
        queue_cmd(CMD_RECV, 0, 3, 0);
        queue_cmd(CMD_SEND, 0, 3, 16'hA5A5);

        // random phases over the extremes of the count, then random counts
        phase_counts = '{0, 31, 16, 1, 17, 2, 0, 0, 0};
        for (int p = 0; p < 9; p++) begin
            if (p >= 6) phase_counts[p] = $urandom_range(0, 31);
            set_task_count(phase_counts[p]);
            calm = (p == 3);
            queue_random(50);
        end

        wait_drained();
        repeat (30) @(negedge i_clk);
        if (fail_count == 0 && expected_res.size() == 0) begin
            $display("round_robin_task_scheduler verification clean");
        end else begin
            $display("round_robin_task_scheduler verification failed");
        end
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/rrts_pkg.sv
hw/rtl/rrts_if.sv
hw/rtl/rrts_ram.sv
hw/rtl/rrts_wrap_add.sv
hw/rtl/round_robin_task_scheduler.sv
hw/rtl/rrts_check.sv
tb/tb.sv
